@@ sv/kktng_pkg.sv @@
// Shared constants, register indexes and control/status types for the
// collective tree node generator. No dependencies.
package kktng_pkg;

  // Sizing of the tree.
  localparam int MAX_NODES  = 256;
  localparam int MAX_FANOUT = 16;
  localparam int MAX_OUT    = 64;
  localparam int K_MIN      = 2;

  // Field widths.
  localparam int NODE_W = 8;
  localparam int K_W    = 5;
  localparam int N_W    = 9;
  localparam int PAR_W  = NODE_W + 1;
  localparam int CNT_W  = 7;
  localparam int SLOT_W = 6;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;

  // Internal widths derived from the tree sizing.
  localparam int LVL_MAX = $clog2(MAX_NODES);
  localparam int LV_W    = $clog2(LVL_MAX + 1);
  localparam int PI_W    = $clog2(LVL_MAX);
  localparam int PW_W    = $clog2(MAX_NODES * MAX_FANOUT);
  localparam int CR_W    = PW_W + 1;
  localparam int DC_W    = $clog2(NODE_W);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_K_VALUE          = 2'd0;
  localparam logic [IDX_W-1:0] REG_TREE_KIND        = 2'd1;
  localparam logic [IDX_W-1:0] REG_REVERSE_CHILDREN = 2'd2;
  localparam logic [IDX_W-1:0] REG_RANK_COUNT       = 2'd3;

  // Register reset values.
  localparam logic [K_W-1:0] K_VALUE_RST    = 5'd2;
  localparam logic           TREE_KIND_RST  = 1'b0;
  localparam logic           REVERSE_RST    = 1'b0;
  localparam logic [N_W-1:0] RANK_COUNT_RST = 9'd256;

  // Tree shape codes.
  localparam logic KIND_KARY    = 1'b0;
  localparam logic KIND_KNOMIAL = 1'b1;

  typedef struct packed {
    logic [K_W-1:0] k_value;
    logic           tree_kind;
    logic           reverse_children;
    logic [N_W-1:0] rank_count;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic kcount;
    logic div_step;
    logic lvl_step;
    logic desc_init;
    logic desc_head;
    logic desc_step;
    logic cnt_init;
    logic cnt_step;
    logic emit_init;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic out_range;
    logic knomial;
    logic root;
    logic div_last;
    logic lvl_done;
    logic desc_end;
    logic desc_hit;
    logic j_last;
    logic cnt_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/kktng_ctrl.sv @@
// Sequencer for the tree node generator: walks one node through setup,
// parent search, child counting and emission. Uses kktng_pkg.
module kktng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  kktng_pkg::sts_t   sts,
  output kktng_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_KCNT  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_LVL   = 4'd4;
  localparam logic [3:0] S_DHEAD = 4'd5;
  localparam logic [3:0] S_DSTEP = 4'd6;
  localparam logic [3:0] S_CINIT = 4'd7;
  localparam logic [3:0] S_CNT   = 4'd8;
  localparam logic [3:0] S_EINIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        priority if (sts.out_range) begin
          state_next = S_EINIT;
        end else if (sts.knomial) begin
          state_next = S_LVL;
        end else begin
          state_next = S_KCNT;
        end
      end
      S_KCNT: begin
        cmd.kcount = 1'b1;
        state_next = sts.root ? S_EINIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_EINIT;
        end
      end
      S_LVL: begin
        if (sts.lvl_done) begin
          cmd.desc_init = 1'b1;
          state_next    = S_DHEAD;
        end else begin
          cmd.lvl_step = 1'b1;
        end
      end
      S_DHEAD: begin
        if (sts.desc_end) begin
          state_next = S_CINIT;
        end else begin
          cmd.desc_head = 1'b1;
          state_next    = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.desc_step = 1'b1;
        // a hit descends into that subrange; a miss on the last subrange drops out of the descent
        priority if (sts.desc_hit) begin
          state_next = S_DHEAD;
        end else if (sts.j_last) begin
          state_next = S_CINIT;
        end else begin
          state_next = S_DSTEP;
        end
      end
      S_CINIT: begin
        cmd.cnt_init = 1'b1;
        state_next   = S_CNT;
      end
      S_CNT: begin
        if (sts.cnt_done) begin
          state_next = S_EINIT;
        end else begin
          cmd.cnt_step = 1'b1;
        end
      end
      S_EINIT: begin
        cmd.emit_init = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/kktng_dp.sv @@
// Datapath of the tree node generator: parent divider, power table, range
// descent, child counter and the output register. Uses kktng_pkg.
module kktng_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  kktng_pkg::cfg_t                          cfg,
  input  logic [kktng_pkg::NODE_W-1:0]             node,
  input  kktng_pkg::cmd_t                          cmd,
  output kktng_pkg::sts_t                          sts,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic signed [kktng_pkg::PAR_W-1:0]       parent,
  output logic [kktng_pkg::CNT_W-1:0]              child_count,
  output logic                                     child_valid,
  output logic [kktng_pkg::SLOT_W-1:0]             child_slot,
  output logic [kktng_pkg::NODE_W-1:0]             child,
  output logic                                     last
);

  localparam int NODE_W = kktng_pkg::NODE_W;
  localparam int K_W    = kktng_pkg::K_W;
  localparam int N_W    = kktng_pkg::N_W;
  localparam int PAR_W  = kktng_pkg::PAR_W;
  localparam int CNT_W  = kktng_pkg::CNT_W;
  localparam int SLOT_W = kktng_pkg::SLOT_W;
  localparam int LV_W   = kktng_pkg::LV_W;
  localparam int PI_W   = kktng_pkg::PI_W;
  localparam int PW_W   = kktng_pkg::PW_W;
  localparam int CR_W   = kktng_pkg::CR_W;
  localparam int DC_W   = kktng_pkg::DC_W;

  logic [K_W-1:0]          kc;
  logic [N_W-1:0]          nc;
  logic [CR_W-1:0]         nc_ext;
  logic [CR_W-1:0]         nd_ext;

  logic [NODE_W-1:0]       nd;
  logic signed [PAR_W-1:0] par;
  logic [CNT_W-1:0]        cnt;
  logic [CR_W-1:0]         base;
  logic [CR_W-1:0]         crank;
  logic [CR_W-1:0]         run;
  logic [NODE_W-1:0]       cur;
  logic [LV_W-1:0]         dep;
  logic [LV_W-1:0]         ci;
  logic [LV_W-1:0]         lv;
  logic [K_W-1:0]          jc;
  logic [PW_W-1:0]         pwr;
  logic [PW_W-1:0]         pw [kktng_pkg::LVL_MAX];
  logic [NODE_W-1:0]       dq;
  logic [K_W-1:0]          dr;
  logic [DC_W-1:0]         dc;
  logic [SLOT_W-1:0]       slot;

  logic [LV_W-1:0]         pidx;
  logic [CR_W-1:0]         sz_ext;
  logic [CR_W-1:0]         base_next;
  logic [PW_W-1:0]         pwr_next;
  logic [CR_W-1:0]         kdiff;
  logic [K_W-1:0]          kcnt;
  logic [K_W:0]            rsh;
  logic [K_W:0]            rdiff;
  logic                    sub_ok;
  logic [K_W-1:0]          r_next;
  logic [NODE_W-1:0]       q_next;
  logic                    knomial;
  logic                    hit;
  logic                    j_last;
  logic                    emit_last;

  // Clamp fan-out and tree size to their legal ranges.
  always_comb begin
    priority if (cfg.k_value < K_W'(kktng_pkg::K_MIN)) begin
      kc = K_W'(kktng_pkg::K_MIN);
    end else if (cfg.k_value > K_W'(kktng_pkg::MAX_FANOUT)) begin
      kc = K_W'(kktng_pkg::MAX_FANOUT);
    end else begin
      kc = cfg.k_value;
    end
    priority if (cfg.rank_count == '0) begin
      nc = N_W'(1);
    end else if (cfg.rank_count > N_W'(kktng_pkg::MAX_NODES)) begin
      nc = N_W'(kktng_pkg::MAX_NODES);
    end else begin
      nc = cfg.rank_count;
    end
  end

  assign nc_ext  = CR_W'(nc);
  assign nd_ext  = CR_W'(nd);
  assign knomial = (cfg.tree_kind == kktng_pkg::KIND_KNOMIAL);

  // Subtree size k^(levels-level-1); descent and child walk never overlap.
  assign pidx   = lv - (cmd.desc_step ? dep : ci) - LV_W'(1);
  assign sz_ext = CR_W'(pw[pidx[PI_W-1:0]]);

  assign base_next = CR_W'(nd) * CR_W'(kc) + CR_W'(1);
  assign pwr_next  = pwr * PW_W'(kc);

  // k-ary child count: min(k, n - base), zero when base is outside the tree.
  assign kdiff = nc_ext - base;
  always_comb begin
    priority if (base >= nc_ext) begin
      kcnt = '0;
    end else if (kdiff > CR_W'(kc)) begin
      kcnt = kc;
    end else begin
      kcnt = kdiff[K_W-1:0];
    end
  end

  // Restoring divider, one quotient bit per step.
  assign rsh    = {dr, dq[NODE_W-1]};
  assign rdiff  = rsh - (K_W+1)'(kc);
  assign sub_ok = (rsh >= (K_W+1)'(kc));
  assign r_next = sub_ok ? rdiff[K_W-1:0] : rsh[K_W-1:0];
  assign q_next = {dq[NODE_W-2:0], sub_ok};

  assign hit       = (nd_ext >= run) && (nd_ext < run + sz_ext);
  assign j_last    = (jc == kc - K_W'(1));
  assign emit_last = (cnt == '0) || ((CNT_W'(slot) + CNT_W'(1)) == cnt);

  always_comb begin
    sts.out_range = (N_W'(nd) >= nc);
    sts.knomial   = knomial;
    sts.root      = (nd == '0);
    sts.div_last  = (dc == DC_W'(NODE_W - 1));
    sts.lvl_done  = (pwr >= PW_W'(nc));
    sts.desc_end  = (cur == nd) || (dep >= lv);
    sts.desc_hit  = hit;
    sts.j_last    = j_last;
    sts.cnt_done  = (ci >= lv) || (crank >= nc_ext);
    sts.emit_last = emit_last;
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      nd  <= node;
      par <= '1;
      cnt <= '0;
    end
    if (cmd.setup) begin
      base <= base_next;
      dq   <= nd - NODE_W'(1);
      dr   <= '0;
      dc   <= '0;
      pwr  <= PW_W'(1);
      lv   <= '0;
    end
    if (cmd.kcount) begin
      cnt   <= CNT_W'(kcnt);
      crank <= cfg.reverse_children ? base + CR_W'(kcnt) - CR_W'(1) : base;
    end
    if (cmd.div_step) begin
      dq <= q_next;
      dr <= r_next;
      dc <= dc + DC_W'(1);
      if (dc == DC_W'(NODE_W - 1)) begin
        par <= $signed({1'b0, q_next});
      end
    end
    if (cmd.lvl_step) begin
      pw[lv[PI_W-1:0]] <= pwr;
      pwr              <= pwr_next;
      lv               <= lv + LV_W'(1);
    end
    if (cmd.desc_init) begin
      cur <= '0;
      dep <= '0;
    end
    if (cmd.desc_head) begin
      run <= CR_W'(cur) + CR_W'(1);
      jc  <= K_W'(1);
    end
    if (cmd.desc_step) begin
      priority if (hit) begin
        par <= $signed({1'b0, cur});
        cur <= run[NODE_W-1:0];
        dep <= dep + LV_W'(1);
      end else if (j_last) begin
        dep <= dep + LV_W'(1);
      end else begin
        run <= run + sz_ext;
        jc  <= jc + K_W'(1);
      end
    end
    if (cmd.cnt_init || (cmd.emit_init && knomial)) begin
      crank <= nd_ext + CR_W'(1);
      ci    <= dep;
      jc    <= K_W'(1);
    end
    if (cmd.cnt_step && (cnt != CNT_W'(kktng_pkg::MAX_OUT))) begin
      cnt <= cnt + CNT_W'(1);
    end
    // Advance the k-nomial child walk by one subrange.
    if (cmd.cnt_step || (cmd.emit_step && knomial)) begin
      crank <= crank + sz_ext;
      if (j_last) begin
        jc <= K_W'(1);
        ci <= ci + LV_W'(1);
      end else begin
        jc <= jc + K_W'(1);
      end
    end
    if (cmd.emit_step && !knomial) begin
      crank <= cfg.reverse_children ? crank - CR_W'(1) : crank + CR_W'(1);
    end
    if (cmd.emit_init) begin
      slot <= '0;
    end
    if (cmd.emit_step) begin
      slot        <= slot + SLOT_W'(1);
      parent      <= par;
      child_count <= cnt;
      child_valid <= (cnt != '0);
      child_slot  <= (cnt != '0) ? slot : '0;
      child       <= (cnt != '0) ? crank[NODE_W-1:0] : '0;
      last        <= emit_last;
    end
  end

  // Output register: hold a beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_child_in_tree: assert property (@(posedge clk) disable iff (rst)
    out_valid && child_valid |-> N_W'(child) < nc)
    else $error("child outside the tree");

  a_slot_below_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && child_valid |-> CNT_W'(child_slot) < child_count)
    else $error("child slot not below child count");

  a_childless_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !child_valid |-> last && (child_count == '0))
    else $error("childless beat is not a single final beat");

  a_desc_level: assert property (@(posedge clk) disable iff (rst)
    cmd.desc_step |-> dep < lv)
    else $error("descent beyond the last level");

  a_walk_level: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_step |-> ci < lv)
    else $error("child count walk beyond the last level");

endmodule

@@ sv/kary_knomial_tree_node_gen_core.sv @@
// Top level of the collective tree node generator: configuration registers,
// sequencer and datapath. Uses kktng_pkg, kktng_ctrl and kktng_dp.
//
// Give it a node number and it returns that node's parent and its ordered
// children in a k-ary or k-nomial tree rooted at node 0, one beat per child
// (a childless node or a node outside the tree gives one beat with
// child_valid low; the root's parent is -1). Nodes are handled one at a time
// and the input stalls until the last beat of a node is loaded into the
// output register. For a k-ary node other than the root, an 8-step
// shift-subtract divider finds the parent during setup. A k-nomial node
// first builds the power table, then descends level by level, probing
// subranges, to find its parent, and makes a counting pass over its
// children. Either kind then emits one beat per cycle while the output is
// not stalled. The user must write configuration through the plain write
// port only while no node is in flight; the block itself does not enforce
// this.
module kary_knomial_tree_node_gen_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [kktng_pkg::IDX_W-1:0]          cfg_index,
  input  logic [kktng_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kktng_pkg::NODE_W-1:0]         node,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [kktng_pkg::PAR_W-1:0]   parent,
  output logic [kktng_pkg::CNT_W-1:0]          child_count,
  output logic                                 child_valid,
  output logic [kktng_pkg::SLOT_W-1:0]         child_slot,
  output logic [kktng_pkg::NODE_W-1:0]         child,
  output logic                                 last
);

  kktng_pkg::cfg_t cfg;
  kktng_pkg::cmd_t cmd;
  kktng_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k_value          <= kktng_pkg::K_VALUE_RST;
      cfg.tree_kind        <= kktng_pkg::TREE_KIND_RST;
      cfg.reverse_children <= kktng_pkg::REVERSE_RST;
      cfg.rank_count       <= kktng_pkg::RANK_COUNT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        kktng_pkg::REG_K_VALUE: begin
          cfg.k_value <= cfg_data[kktng_pkg::K_W-1:0];
        end
        kktng_pkg::REG_TREE_KIND: begin
          cfg.tree_kind <= cfg_data[0];
        end
        kktng_pkg::REG_REVERSE_CHILDREN: begin
          cfg.reverse_children <= cfg_data[0];
        end
        kktng_pkg::REG_RANK_COUNT: begin
          cfg.rank_count <= cfg_data[kktng_pkg::N_W-1:0];
        end
      endcase
    end
  end

  kktng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kktng_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .node        (node),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .parent      (parent),
    .child_count (child_count),
    .child_valid (child_valid),
    .child_slot  (child_slot),
    .child       (child),
    .last        (last)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking bench for kary_knomial_tree_node_gen_core: a directed table
// followed by randomized phases, each beat checked against an in-bench tree
// model or a typed expected beat. Depends on kktng_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kktng_pkg::*;

  typedef struct {
    logic [PAR_W-1:0]  parent;
    logic [CNT_W-1:0]  child_count;
    logic              child_valid;
    logic [SLOT_W-1:0] child_slot;
    logic [NODE_W-1:0] child;
    logic              last;
  } tree_beat_t;

  typedef struct {
    cfg_t              cfg;
    logic [NODE_W-1:0] nd;
    bit                typed;
    int                tpar;
  } node_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write_en = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [NODE_W-1:0]        node = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [PAR_W-1:0]  parent;
  logic [CNT_W-1:0]         child_count;
  logic                     child_valid;
  logic [SLOT_W-1:0]        child_slot;
  logic [NODE_W-1:0]        child;
  logic                     last;

  tree_beat_t pending_beats[$];
  node_row_t  node_table[$];
  cfg_t       tree_cfg;
  tree_beat_t typed_beat;
  bit         typed_armed = 1'b0;
  bit         calm = 1'b0;
  int         fail_count = 0;
  int         stall_hold = 0;

  kary_knomial_tree_node_gen_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .node         (node),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .parent       (parent),
    .child_count  (child_count),
    .child_valid  (child_valid),
    .child_slot   (child_slot),
    .child        (child),
    .last         (last)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int subtree_size(input int k, input int e);
    int sz;
    sz = 1;
    for (int i = 0; i < e; i++) sz = sz * k;
    return sz;
  endfunction

  // Work out every beat one node produces under the current register set.
  function automatic void predict_tree_beats(input logic [NODE_W-1:0] nd);
    int k, n, me, par, levels, t, cur, depth, run, sz, crank, id, nres;
    bit moved, stuck;
    int kids[$];
    tree_beat_t b;
    k = int'(tree_cfg.k_value);
    n = int'(tree_cfg.rank_count);
    me = int'(nd);
    if (k < K_MIN) k = K_MIN;
    if (k > MAX_FANOUT) k = MAX_FANOUT;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    par = -1;
    if (me < n) begin
      if (tree_cfg.tree_kind == KIND_KARY) begin
        if (me != 0) par = (me - 1) / k;
        for (int j = 0; j < k; j++) begin
          id = me * k + 1 + (tree_cfg.reverse_children ? k - 1 - j : j);
          if (id < n && kids.size() < MAX_OUT) kids.push_back(id);
        end
      end else begin
        levels = 0;
        for (t = n - 1; t != 0; t = t / k) levels++;
        cur = 0;
        depth = 0;
        stuck = 1'b0;
        // Descend through the subranges until the node's own subtree is found.
        while (cur != me && depth < levels && !stuck) begin
          run = cur + 1;
          sz = subtree_size(k, levels - depth - 1);
          moved = 1'b0;
          for (int j = 1; j < k && !moved; j++) begin
            if (me >= run && me < run + sz) begin
              par = cur;
              cur = run;
              moved = 1'b1;
            end else begin
              run = run + sz;
            end
          end
          depth++;
          stuck = !moved;
        end
        crank = me + 1;
        for (int i = depth; i < levels; i++) begin
          sz = subtree_size(k, levels - i - 1);
          for (int j = 1; j < k; j++) begin
            if (crank < n && kids.size() < MAX_OUT) kids.push_back(crank);
            crank = crank + sz;
          end
        end
      end
    end
    nres = (kids.size() != 0) ? kids.size() : 1;
    for (int r = 0; r < nres; r++) begin
      b.parent      = par[PAR_W-1:0];
      b.child_count = CNT_W'(kids.size());
      b.child_valid = (kids.size() != 0);
      b.child_slot  = (kids.size() != 0) ? SLOT_W'(r) : '0;
      b.child       = (kids.size() != 0) ? NODE_W'(kids[r]) : '0;
      b.last        = (r == nres - 1);
      pending_beats.push_back(b);
    end
  endfunction

  // Record expectations for every input beat the core takes.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (typed_armed) begin
        pending_beats.push_back(typed_beat);
        typed_armed = 1'b0;
      end else begin
        predict_tree_beats(node);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : out_check
    tree_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, parent %0d child %0d", $time, parent, child);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("parent", int'($signed(want.parent)), int'(parent));
        check_field("child_count", int'(want.child_count), int'(child_count));
        check_field("child_valid", int'(want.child_valid), int'(child_valid));
        check_field("child_slot", int'(want.child_slot), int'(child_slot));
        check_field("child", int'(want.child), int'(child));
        check_field("last", int'(want.last), int'(last));
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b1;
      stall_hold = idle_len() - 1;
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_node(input logic [NODE_W-1:0] nd, input int gap);
    in_valid <= 1'b1;
    node <= nd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input int dk, input int dkind, input int drev, input int dn);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_K_VALUE;
    cfg_data <= CFG_W'(dk);
    @(negedge clk);
    cfg_index <= REG_TREE_KIND;
    cfg_data <= CFG_W'(dkind);
    @(negedge clk);
    cfg_index <= REG_REVERSE_CHILDREN;
    cfg_data <= CFG_W'(drev);
    @(negedge clk);
    cfg_index <= REG_RANK_COUNT;
    cfg_data <= CFG_W'(dn);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    tree_cfg.k_value = dk[K_W-1:0];
    tree_cfg.tree_kind = dkind[0];
    tree_cfg.reverse_children = drev[0];
    tree_cfg.rank_count = dn[N_W-1:0];
  endtask

  task automatic add_row(input int k, input int kind, input int rev, input int n,
                         input int nd, input bit typed, input int tpar);
    node_row_t row;
    row.cfg.k_value = k[K_W-1:0];
    row.cfg.tree_kind = kind[0];
    row.cfg.reverse_children = rev[0];
    row.cfg.rank_count = n[N_W-1:0];
    row.nd = nd[NODE_W-1:0];
    row.typed = typed;
    row.tpar = tpar;
    node_table.push_back(row);
  endtask

  initial begin
    node_row_t row;
    int eff_n, gap;
    logic [NODE_W-1:0] nd;

    tree_cfg.k_value = K_VALUE_RST;
    tree_cfg.tree_kind = TREE_KIND_RST;
    tree_cfg.reverse_children = REVERSE_RST;
    tree_cfg.rank_count = RANK_COUNT_RST;

    // Reset register set first, then sizes and fan-outs clamped at both ends, then k-nomial trees.
    add_row(2, int'(KIND_KARY), 0, 256, 0, 0, 0);
    add_row(2, int'(KIND_KARY), 0, 256, 255, 1, 127);
    add_row(2, int'(KIND_KARY), 0, 256, 127, 0, 0);
    add_row(2, int'(KIND_KARY), 0, 256, 1, 0, 0);
    add_row(2, int'(KIND_KARY), 0, 1, 0, 1, -1);
    add_row(2, int'(KIND_KARY), 0, 1, 5, 1, -1);
    add_row(2, int'(KIND_KARY), 0, 0, 0, 1, -1);
    add_row(2, int'(KIND_KARY), 0, 0, 1, 1, -1);
    add_row(2, int'(KIND_KARY), 0, 511, 255, 1, 127);
    add_row(0, int'(KIND_KARY), 0, 10, 1, 0, 0);
    add_row(1, int'(KIND_KARY), 0, 10, 4, 0, 0);
    add_row(16, int'(KIND_KARY), 1, 256, 0, 0, 0);
    add_row(16, int'(KIND_KARY), 1, 256, 15, 0, 0);
    add_row(31, int'(KIND_KARY), 0, 256, 0, 0, 0);
    add_row(16, int'(KIND_KARY), 0, 20, 19, 1, 1);
    add_row(2, int'(KIND_KNOMIAL), 0, 256, 0, 0, 0);
    add_row(2, int'(KIND_KNOMIAL), 0, 256, 255, 0, 0);
    add_row(2, int'(KIND_KNOMIAL), 0, 256, 128, 0, 0);
    add_row(16, int'(KIND_KNOMIAL), 0, 256, 0, 0, 0);
    add_row(16, int'(KIND_KNOMIAL), 0, 256, 17, 0, 0);
    add_row(3, int'(KIND_KNOMIAL), 0, 100, 50, 0, 0);
    add_row(4, int'(KIND_KNOMIAL), 1, 64, 0, 0, 0);
    add_row(2, int'(KIND_KNOMIAL), 0, 1, 0, 1, -1);
    add_row(5, int'(KIND_KNOMIAL), 0, 30, 200, 1, -1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (node_table[i]) begin
      row = node_table[i];
      if (row.cfg != tree_cfg) begin
        drain();
        apply_config(int'(row.cfg.k_value), int'(row.cfg.tree_kind),
                     int'(row.cfg.reverse_children), int'(row.cfg.rank_count));
      end
      if (row.typed) begin
        typed_beat.parent = row.tpar[PAR_W-1:0];
        typed_beat.child_count = '0;
        typed_beat.child_valid = 1'b0;
        typed_beat.child_slot = '0;
        typed_beat.child = '0;
        typed_beat.last = 1'b1;
        typed_armed = 1'b1;
      end
      send_node(row.nd, ($urandom_range(0, 1) != 0) ? 0 : idle_len());
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      case (ph)
        0: apply_config(2, int'(KIND_KARY), 0, 256);
        1: apply_config(16, int'(KIND_KNOMIAL), 0, 256);
        2: apply_config(16, int'(KIND_KARY), 1, 256);
        3: apply_config(2, int'(KIND_KNOMIAL), 1, 256);
        default: begin
          apply_config(($urandom_range(0, 9) < 8) ? $urandom_range(2, 16) : $urandom_range(0, 511),
                       $urandom_range(0, 511), $urandom_range(0, 511),
                       ($urandom_range(0, 9) < 6) ? $urandom_range(1, 256) :
                       ($urandom_range(0, 1) != 0) ? $urandom_range(2, 40) :
                       $urandom_range(0, 511));
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      eff_n = int'(tree_cfg.rank_count);
      if (eff_n < 1) eff_n = 1;
      if (eff_n > MAX_NODES) eff_n = MAX_NODES;
      for (int i = 0; i < 14; i++) begin
        // Hold the sender now and then until the output side has caught up.
        if ($urandom_range(0, 29) == 0) drain();
        if ($urandom_range(0, 9) < 8) nd = NODE_W'($urandom_range(0, eff_n - 1));
        else nd = NODE_W'($urandom_range(0, 255));
        gap = (calm || $urandom_range(0, 1) != 0) ? 0 : idle_len();
        send_node(nd, gap);
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/kktng_pkg.sv
sv/kktng_ctrl.sv
sv/kktng_dp.sv
sv/kary_knomial_tree_node_gen_core.sv
test/testbench.sv
